>>> src/sir_pkg.sv
// Shared types and constants for the sorted ID registry.
`default_nettype none
package sir_pkg;

    localparam int CAPACITY_DEF = 64;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_ALLOC  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ALLOC_START,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_SCAN_BUMP,
        OP_HIT,
        OP_INS_INIT,
        OP_UP_RD,
        OP_UP_WR,
        OP_INS_PUT,
        OP_DEL_INIT,
        OP_DN_RD,
        OP_DN_WR,
        OP_DEL_DONE
    } t_op;

    typedef struct packed {
        t_op     op;
        logic    set_st;
        t_status st;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic key_zero;
        logic ctr_wrap;
        logic key_wrap;
        logic at_end;
        logic id_lt;
        logic id_eq;
        logic hit;
        logic full;
        logic up_done;
        logic dn_done;
    } t_flags;

endpackage
`default_nettype wire

>>> src/sir_dp.sv
// Datapath: ID and handle memories, scan position, shift index, counters, result registers.
`default_nettype none
module sir_dp #(
    parameter int CAPACITY = sir_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sir_pkg::t_cmd   i_cmd,
    input  wire logic [1:0]      i_req_type,
    input  wire logic [31:0]     i_entry_id,
    input  wire logic [15:0]     i_entry_handle,
    output sir_pkg::t_flags      o_flags,
    output logic [2:0]           o_status,
    output logic [15:0]          o_found_handle,
    output logic [31:0]          o_given_id,
    output logic [CW-1:0]        o_entry_count
);
    import sir_pkg::*;

    logic [31:0] m_ids [CAPACITY];
    logic [15:0] m_hdl [CAPACITY];

    t_req        r_req;
    logic [31:0] r_key;
    logic [15:0] r_handle;
    logic [31:0] r_ctr;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_count;
    logic        r_hit;
    t_status     r_status;
    logic [15:0] r_found;
    logic [31:0] r_given;
    logic [31:0] r_rd_id;
    logic [15:0] r_rd_hdl;

    logic [CW-1:0] idx_dec;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic [31:0]   wr_id;
    logic [15:0]   wr_hdl;

    assign idx_dec = r_idx - CW'(1);

    always_comb begin
        rd_addr = r_pos[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_id   = r_rd_id;
        wr_hdl  = r_rd_hdl;
        case (i_cmd.op)
            OP_UP_RD: rd_addr = idx_dec[AW-1:0];
            OP_DN_RD: rd_addr = r_idx[AW-1:0];
            OP_UP_WR: wr_en = 1'b1;
            OP_DN_WR: begin
                wr_en   = 1'b1;
                wr_addr = idx_dec[AW-1:0];
            end
            OP_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_pos[AW-1:0];
                wr_id   = r_key;
                wr_hdl  = r_handle;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            m_ids[wr_addr] <= wr_id;
            m_hdl[wr_addr] <= wr_hdl;
        end
        r_rd_id  <= m_ids[rd_addr];
        r_rd_hdl <= m_hdl[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ctr   <= '0;
        end else begin
            case (i_cmd.op)
                OP_ALLOC_START: r_ctr <= r_ctr + 32'd1;
                OP_SCAN_BUMP:   r_ctr <= r_key + 32'd1;
                OP_INS_PUT:     r_count <= r_count + CW'(1);
                OP_DEL_DONE:    r_count <= r_count - CW'(1);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_st) begin
            r_status <= i_cmd.st;
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_req    <= t_req'(i_req_type);
                r_key    <= i_entry_id;
                r_handle <= i_entry_handle;
                r_pos    <= '0;
                r_hit    <= 1'b0;
                r_found  <= '0;
                r_given  <= '0;
            end
            OP_ALLOC_START: r_key <= r_ctr + 32'd1;
            OP_SCAN_NEXT:   r_pos <= r_pos + CW'(1);
            OP_SCAN_BUMP: begin
                r_key <= r_key + 32'd1;
                r_pos <= r_pos + CW'(1);
            end
            OP_HIT: begin
                r_hit <= 1'b1;
                if (r_req == REQ_LOOKUP || r_req == REQ_DELETE) begin
                    r_found <= r_rd_hdl;
                end
            end
            OP_INS_INIT: r_idx <= r_count;
            OP_UP_WR:    r_idx <= idx_dec;
            OP_INS_PUT:  r_given <= (r_req == REQ_ALLOC) ? r_key : 32'd0;
            OP_DEL_INIT: r_idx <= r_pos + CW'(1);
            OP_DN_WR:    r_idx <= r_idx + CW'(1);
            default: ;
        endcase
    end

    always_comb begin
        o_flags.req      = r_req;
        o_flags.key_zero = (r_key == 32'd0);
        o_flags.ctr_wrap = &r_ctr;
        o_flags.key_wrap = &r_key;
        o_flags.at_end   = (r_pos == r_count);
        o_flags.id_lt    = (r_rd_id < r_key);
        o_flags.id_eq    = (r_rd_id == r_key);
        o_flags.hit      = r_hit;
        o_flags.full     = (r_count == CW'(CAPACITY));
        o_flags.up_done  = (r_idx == r_pos);
        o_flags.dn_done  = (r_idx == r_count);
    end

    assign o_status       = r_status;
    assign o_found_handle = r_found;
    assign o_given_id     = r_given;
    assign o_entry_count  = r_count;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");
    a_put_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_INS_PUT |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow count");
    a_del_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_DEL_DONE |=> r_count == $past(r_count) - CW'(1))
        else $error("delete did not shrink count");
    a_put_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_INS_PUT |-> r_count < CW'(CAPACITY))
        else $error("insert into full table");

endmodule
`default_nettype wire

>>> src/sir_ctrl.sv
// Controller: sequences scan, shift and result handshake for each request.
`default_nettype none
module sir_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    input  wire sir_pkg::t_flags i_flags,
    output sir_pkg::t_cmd        o_cmd
);
    import sir_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DECIDE,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd.op     = OP_NONE;
        o_cmd.set_st = 1'b0;
        o_cmd.st     = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_flags.req == REQ_ALLOC) begin
                    o_cmd.op = OP_ALLOC_START;
                    if (i_flags.ctr_wrap) begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st     = ST_INVALID;
                        n_state      = S_OUT;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end else if (i_flags.key_zero) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_INVALID;
                    n_state      = S_OUT;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (i_flags.at_end) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.op = OP_SCAN_RD;
                    n_state  = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_flags.id_lt) begin
                    o_cmd.op = OP_SCAN_NEXT;
                    n_state  = S_SCAN_RD;
                end else if (i_flags.id_eq && i_flags.req == REQ_ALLOC) begin
                    o_cmd.op = OP_SCAN_BUMP;
                    if (i_flags.key_wrap) begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st     = ST_INVALID;
                        n_state      = S_OUT;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end else if (i_flags.id_eq) begin
                    o_cmd.op = OP_HIT;
                    n_state  = S_DECIDE;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd.set_st = 1'b1;
                n_state      = S_OUT;
                unique case (i_flags.req)
                    REQ_INSERT, REQ_ALLOC: begin
                        if (i_flags.hit) begin
                            o_cmd.st = ST_PRESENT;
                        end else if (i_flags.full) begin
                            o_cmd.st = ST_FULL;
                        end else begin
                            o_cmd.set_st = 1'b0;
                            o_cmd.op     = OP_INS_INIT;
                            n_state      = S_UP_RD;
                        end
                    end
                    REQ_LOOKUP: begin
                        o_cmd.st = i_flags.hit ? ST_OK : ST_NOT_FOUND;
                    end
                    REQ_DELETE: begin
                        if (i_flags.hit) begin
                            o_cmd.set_st = 1'b0;
                            o_cmd.op     = OP_DEL_INIT;
                            n_state      = S_DN_RD;
                        end else begin
                            o_cmd.st = ST_NOT_FOUND;
                        end
                    end
                endcase
            end
            S_UP_RD: begin
                if (i_flags.up_done) begin
                    o_cmd.op     = OP_INS_PUT;
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_OK;
                    n_state      = S_OUT;
                end else begin
                    o_cmd.op = OP_UP_RD;
                    n_state  = S_UP_WR;
                end
            end
            S_UP_WR: begin
                o_cmd.op = OP_UP_WR;
                n_state  = S_UP_RD;
            end
            S_DN_RD: begin
                if (i_flags.dn_done) begin
                    o_cmd.op     = OP_DEL_DONE;
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_OK;
                    n_state      = S_OUT;
                end else begin
                    o_cmd.op = OP_DN_RD;
                    n_state  = S_DN_WR;
                end
            end
            S_DN_WR: begin
                o_cmd.op = OP_DN_WR;
                n_state  = S_DN_RD;
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = (n_state == S_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result shown while taking requests");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_out_valid && !o_in_stall)
        else $error("result not retired after handoff");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == OP_LOAD |-> i_in_valid && !o_in_stall)
        else $error("load without accepted request");

endmodule
`default_nettype wire

>>> src/sorted_id_registry.sv
// Top level of the sorted ID registry: controller plus datapath.
// Usage:
//  Request channel: i_in_valid with i_req_type, i_entry_id, i_entry_handle;
//  taken on a clock edge with i_in_valid high and o_in_stall low.
//  Result channel: o_out_valid with o_status, o_found_handle, o_given_id,
//  o_entry_count; taken on an edge with o_out_valid high and i_out_stall low.
//  One request is worked at a time; o_in_stall is high from acceptance until
//  its result is taken.
//  The table is scanned in ascending order, through one memory read port with
//  registered data. Insert and allocate then move every entry above the slot
//  up by one, delete moves every entry above it down by one. The next request
//  can be taken in the cycle after the result is taken; an invalid ID can
//  skip the scan and the shift.
//  Reset (synchronous, active low) empties the table and zeros the ID counter;
//  memory contents are not cleared.
//  While the receiver stalls, the result holds and no new request is taken.
`default_nettype none
module sorted_id_registry #(
    parameter int CAPACITY = sir_pkg::CAPACITY_DEF,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [1:0]    i_req_type,
    input  wire logic [31:0]   i_entry_id,
    input  wire logic [15:0]   i_entry_handle,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [2:0]         o_status,
    output logic [15:0]        o_found_handle,
    output logic [31:0]        o_given_id,
    output logic [CW-1:0]      o_entry_count
);
    import sir_pkg::*;

    t_cmd   cmd;
    t_flags flags;

    sir_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_flags     (flags),
        .o_cmd       (cmd)
    );

    sir_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_req_type     (i_req_type),
        .i_entry_id     (i_entry_id),
        .i_entry_handle (i_entry_handle),
        .o_flags        (flags),
        .o_status       (o_status),
        .o_found_handle (o_found_handle),
        .o_given_id     (o_given_id),
        .o_entry_count  (o_entry_count)
    );

endmodule
`default_nettype wire
